FILE: rtl/core/dfeg_pkg.sv
// dfeg_pkg: shared widths, register indexes and struct types of the dipole
// force/energy gradient block. No dependencies.
package dfeg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_BITS  = 48;
  localparam int DIFF_W    = 34;   // first minus second position
  localparam int DIST_W    = 34;   // integer square root of a 68 bit radicand
  localparam int RAD_W     = 2 * DIST_W;
  localparam int CFG_W     = 31;
  localparam int QUO_W     = 30;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 35;
  localparam int TOP_W     = 5;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_MIN_FULL = 2'd0;
  localparam logic [IDX_W-1:0] REG_FORCE    = 2'd1;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_full;
    logic [CFG_W-1:0] force_mag;
  } cfg_t;

endpackage

FILE: rtl/core/dfeg_front.sv
// dfeg_front: input side, forms the endpoint difference vector and holds
// accepted words in a two entry queue. Uses dfeg_pkg.
module dfeg_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           first_rest_x,
  input  logic signed [31:0]           first_rest_y,
  input  logic signed [31:0]           first_disp_x,
  input  logic signed [31:0]           first_disp_y,
  input  logic signed [31:0]           second_rest_x,
  input  logic signed [31:0]           second_rest_y,
  input  logic signed [31:0]           second_disp_x,
  input  logic signed [31:0]           second_disp_y,
  input  logic                         last_in,
  input  logic                         q_pop,
  output dfeg_pkg::q_stat_t            q_stat,
  output dfeg_pkg::item_t              q_item
);

  localparam int DIFF_W = dfeg_pkg::DIFF_W;

  dfeg_pkg::item_t entries [2];
  dfeg_pkg::item_t item_new;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;

  always_comb begin
    item_new.dx = (DIFF_W'(first_rest_x) + DIFF_W'(first_disp_x))
                - (DIFF_W'(second_rest_x) + DIFF_W'(second_disp_x));
    item_new.dy = (DIFF_W'(first_rest_y) + DIFF_W'(first_disp_y))
                - (DIFF_W'(second_rest_y) + DIFF_W'(second_disp_y));
    item_new.last = last_in;
  end

  assign in_stall     = (count == 2'd2);
  assign push         = in_valid && !in_stall;
  assign q_stat.valid = (count != 2'd0);
  assign q_stat.full  = in_stall;
  assign q_item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/dfeg_isqrt.sv
// dfeg_isqrt: integer square root, one result bit per cycle by the
// digit-by-digit method. Uses dfeg_pkg.
module dfeg_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dfeg_pkg::RAD_W-1:0]      rad,
  output logic                            busy,
  output logic [dfeg_pkg::DIST_W-1:0]     root
);

  logic [dfeg_pkg::RAD_W-1:0]    rad_sh;
  logic [dfeg_pkg::DIST_W+1:0]   rem;
  logic [dfeg_pkg::DIST_W+3:0]   rem_t;
  logic [dfeg_pkg::DIST_W+3:0]   trial;
  logic [5:0]                    cnt;

  assign rem_t = {rem, rad_sh[dfeg_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[dfeg_pkg::RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem  <= (dfeg_pkg::DIST_W+2)'(rem_t - trial);
        root <= {root[dfeg_pkg::DIST_W-2:0], 1'b1};
      end else begin
        rem  <= (dfeg_pkg::DIST_W+2)'(rem_t);
        root <= {root[dfeg_pkg::DIST_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(dfeg_pkg::DIST_W - 1);
    end else if (busy) begin
      if (cnt == 6'd0) busy <= 1'b0;
      else cnt <= cnt - 6'd1;
    end
  end

endmodule

FILE: rtl/core/dfeg_div.sv
// dfeg_div: restoring divider, one quotient bit per cycle from bit top
// down to bit zero; the quotient must fit below bit top+1. Uses dfeg_pkg.
module dfeg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dfeg_pkg::NUM_W-1:0]    num,
  input  logic [dfeg_pkg::DEN_W-1:0]    den,
  input  logic [dfeg_pkg::TOP_W-1:0]    top,
  output logic                          busy,
  output logic [dfeg_pkg::QUO_W-1:0]    quo
);

  logic [dfeg_pkg::NUM_W-1:0] rem;
  logic [dfeg_pkg::NUM_W-1:0] dsh;
  logic [dfeg_pkg::TOP_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= dfeg_pkg::NUM_W'(den) << top;
      quo <= '0;
    end else if (busy) begin
      dsh <= dsh >> 1;
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[dfeg_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[dfeg_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= top;
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

endmodule

FILE: rtl/core/dfeg_back.sv
// dfeg_back: per-dipole sequencer: distance, piecewise energy and gradient,
// saturating accumulation, output scaling and the result register.
// Uses dfeg_pkg, dfeg_isqrt and dfeg_div.
module dfeg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  dfeg_pkg::cfg_t               cfg,
  input  dfeg_pkg::q_stat_t            q_stat,
  input  dfeg_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [46:0]                  energy_sum,
  output logic signed [47:0]           grad_x_sum,
  output logic signed [47:0]           grad_y_sum,
  output logic                         last_out
);

  localparam int AW = dfeg_pkg::ACC_BITS;
  localparam int FB = dfeg_pkg::FRAC_BITS;
  localparam int DW = dfeg_pkg::DIST_W;
  localparam int CW = dfeg_pkg::CFG_W;
  localparam int HW = AW / 2;
  localparam int PW = AW + CW;

  localparam logic signed [AW+1:0] ACC_MAX = (AW+2)'((64'sd1 <<< (AW - 1)) - 64'sd1);
  localparam logic signed [AW+1:0] ACC_MIN = ~ACC_MAX;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQS  = 4'd2;
  localparam logic [3:0] S_SQW  = 4'd3;
  localparam logic [3:0] S_CLS  = 4'd4;
  localparam logic [3:0] S_DV1  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_DV2  = 4'd7;
  localparam logic [3:0] S_DV3  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_SCA  = 4'd10;
  localparam logic [3:0] S_SCB  = 4'd11;
  localparam logic [3:0] S_SCC  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]               state;
  logic [3:0]               state_next;

  logic signed [DW-1:0]     dx;
  logic signed [DW-1:0]     dy;
  logic                     last;
  logic [DW-1:0]            mx;
  logic [DW-1:0]            my;
  logic [2*DW-1:0]          sqx;
  logic [2*DW-1:0]          sqy;
  logic                     is_mid;
  logic [CW-1:0]            u;
  logic [47:0]              px;
  logic [47:0]              py;
  logic [2*CW-1:0]          uu;
  logic signed [AW:0]       e_val;
  logic signed [AW:0]       gx_val;
  logic signed [AW:0]       gy_val;
  logic signed [AW-1:0]     acc_e;
  logic signed [AW-1:0]     acc_x;
  logic signed [AW-1:0]     acc_y;
  logic [1:0]               j;
  logic [PW-1:0]            plo;
  logic [PW-1:0]            total;
  logic [AW-1:0]            res [3];

  logic                     sq_start;
  logic                     sq_busy;
  logic [DW-1:0]            d;
  logic                     dvx_start;
  logic                     dvy_start;
  logic                     dvx_busy;
  logic                     dvy_busy;
  logic [dfeg_pkg::NUM_W-1:0] dvx_num;
  logic [dfeg_pkg::NUM_W-1:0] dvy_num;
  logic [dfeg_pkg::DEN_W-1:0] dvx_den;
  logic [dfeg_pkg::DEN_W-1:0] dvy_den;
  logic [dfeg_pkg::TOP_W-1:0] dvx_top;
  logic [dfeg_pkg::QUO_W-1:0] qx;
  logic [dfeg_pkg::QUO_W-1:0] qy;

  logic                     lin;
  logic                     mid;
  logic [DW+2:0]            lin_num;
  logic [DW+1:0]            u_wide;
  logic signed [AW-1:0]     acc_sel;
  logic                     neg;
  logic [AW-1:0]            mag;
  logic [PW-FB-1:0]         q_sc;
  logic [AW-1:0]            limit;
  logic [AW-1:0]            q_sat;
  logic                     out_free;

  assign mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign my = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // classification of the distance against the full-force distance
  assign lin     = d > DW'(cfg.min_full);
  assign mid     = !lin && ({1'b0, d, 1'b0} > (DW+2)'(cfg.min_full));
  assign lin_num = {1'b0, d, 2'b00} - (DW+3)'(3 * (DW+3)'(cfg.min_full));
  assign u_wide  = {d, 1'b0} - (DW+2)'(cfg.min_full);

  function automatic logic signed [AW:0] sat_add(logic signed [AW-1:0] acc,
                                                 logic signed [AW:0] v);
    logic signed [AW+1:0] s;
    s = (AW+2)'(acc) + (AW+2)'(v);
    if (s > ACC_MAX) return (AW+1)'(ACC_MAX);
    if (s < ACC_MIN) return (AW+1)'(ACC_MIN);
    return (AW+1)'(s);
  endfunction

  always_comb begin
    case (j)
      2'd0:    acc_sel = acc_e;
      2'd1:    acc_sel = acc_x;
      default: acc_sel = acc_y;
    endcase
    neg   = acc_sel[AW-1];
    mag   = neg ? AW'(-acc_sel) : AW'(acc_sel);
    q_sc  = total[PW-1:FB];
    limit = AW'(ACC_MAX) + AW'(neg);
    q_sat = (q_sc > (PW-FB)'(limit)) ? limit : AW'(q_sc);
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    sq_start   = 1'b0;
    dvx_start  = 1'b0;
    dvy_start  = 1'b0;
    dvx_num    = {{(dfeg_pkg::NUM_W-DW-FB){1'b0}}, mx, {FB{1'b0}}};
    dvy_num    = {{(dfeg_pkg::NUM_W-DW-FB){1'b0}}, my, {FB{1'b0}}};
    dvx_den    = dfeg_pkg::DEN_W'(d);
    dvy_den    = dfeg_pkg::DEN_W'(d);
    dvx_top    = dfeg_pkg::TOP_W'(FB);
    unique case (state)
      S_IDLE: begin
        if (q_stat.valid) begin
          q_pop      = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ:  state_next = S_SQS;
      S_SQS: begin
        sq_start   = 1'b1;
        state_next = S_SQW;
      end
      S_SQW: if (!sq_busy) state_next = S_CLS;
      S_CLS: begin
        if (lin || mid) begin
          dvx_start  = 1'b1;
          dvy_start  = 1'b1;
          state_next = S_DV1;
        end else begin
          state_next = S_ACC;
        end
      end
      S_DV1: begin
        if (!dvx_busy && !dvy_busy) state_next = is_mid ? S_MUL : S_ACC;
      end
      S_MUL: begin
        // quadratic piece: scale both unit gradients by u / m
        dvx_num    = dfeg_pkg::NUM_W'(px);
        dvy_num    = dfeg_pkg::NUM_W'(py);
        dvx_den    = dfeg_pkg::DEN_W'(cfg.min_full);
        dvy_den    = dfeg_pkg::DEN_W'(cfg.min_full);
        dvx_start  = 1'b1;
        dvy_start  = 1'b1;
        state_next = S_DV2;
      end
      S_DV2: begin
        if (!dvx_busy && !dvy_busy) begin
          dvx_num    = dfeg_pkg::NUM_W'(uu);
          dvx_den    = dfeg_pkg::DEN_W'({cfg.min_full, 2'b00});
          dvx_top    = dfeg_pkg::TOP_W'(dfeg_pkg::QUO_W - 1);
          dvx_start  = 1'b1;
          state_next = S_DV3;
        end
      end
      S_DV3: if (!dvx_busy) state_next = S_ACC;
      S_ACC: state_next = S_SCA;
      S_SCA: state_next = S_SCB;
      S_SCB: state_next = S_SCC;
      S_SCC: state_next = (j == 2'd2) ? S_OUT : S_SCA;
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc_e     <= '0;
      acc_x     <= '0;
      acc_y     <= '0;
      j         <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_ACC) begin
        acc_e <= AW'(sat_add(acc_e, e_val));
        acc_x <= AW'(sat_add(acc_x, gx_val));
        acc_y <= AW'(sat_add(acc_y, gy_val));
        j     <= 2'd0;
      end
      if (state == S_SCC) j <= j + 2'd1;
      if (state == S_OUT && out_free) begin
        if (last) begin
          acc_e <= '0;
          acc_x <= '0;
          acc_y <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dx   <= q_item.dx;
      dy   <= q_item.dy;
      last <= q_item.last;
    end
    if (state == S_SQ) begin
      sqx <= mx * mx;
      sqy <= my * my;
    end
    if (state == S_CLS) begin
      is_mid <= mid;
      u      <= CW'(u_wide);
      e_val  <= lin ? (AW+1)'(lin_num >> 2) : '0;
      gx_val <= '0;
      gy_val <= '0;
    end
    if (state == S_DV1 && !dvx_busy && !dvy_busy) begin
      gx_val <= dx[DW-1] ? -(AW+1)'(qx) : (AW+1)'(qx);
      gy_val <= dy[DW-1] ? -(AW+1)'(qy) : (AW+1)'(qy);
    end
    if (state == S_DV2 && !dvx_busy && !dvy_busy) begin
      gx_val <= dx[DW-1] ? -(AW+1)'(qx) : (AW+1)'(qx);
      gy_val <= dy[DW-1] ? -(AW+1)'(qy) : (AW+1)'(qy);
    end
    if (state == S_DV3 && !dvx_busy) begin
      e_val <= (AW+1)'(qx);
    end
    if (state == S_DV1 && is_mid && !dvx_busy && !dvy_busy) begin
      // quotients of the first division are below 2^17
      px <= 48'(qx[FB:0]) * 48'(u);
      py <= 48'(qy[FB:0]) * 48'(u);
      uu <= u * u;
    end
    if (state == S_SCA) plo <= PW'(mag[HW-1:0]) * PW'(cfg.force_mag);
    if (state == S_SCB) total <= ((PW'(mag[AW-1:HW]) * PW'(cfg.force_mag)) << HW) + plo;
    if (state == S_SCC) res[j] <= neg ? AW'(-q_sat) : q_sat;
    if (state == S_OUT && out_free) begin
      energy_sum <= res[0][46:0];
      grad_x_sum <= res[1];
      grad_y_sum <= res[2];
      last_out   <= last;
    end
  end

  dfeg_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sqx + sqy),
    .busy  (sq_busy),
    .root  (d)
  );

  dfeg_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (dvx_start),
    .num   (dvx_num),
    .den   (dvx_den),
    .top   (dvx_top),
    .busy  (dvx_busy),
    .quo   (qx)
  );

  dfeg_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (dvy_start),
    .num   (dvy_num),
    .den   (dvy_den),
    .top   (dfeg_pkg::TOP_W'(FB)),
    .busy  (dvy_busy),
    .quo   (qy)
  );

endmodule

FILE: rtl/core/dipole_force_energy_gradient_top.sv
// channel   | handshake           | payload
// input     | in_valid / in_stall | eight Q16.16 positions and displacements, last_in
// result    | out_valid/out_stall | energy_sum, grad_x_sum, grad_y_sum, last_out
// config    | wr_en               | wr_index, wr_data
// from the queue pop to the result word, a bit-serial square root of 34 result
// bits and the one-bit-per-cycle dividers (17 or 30 steps) set the time one
// item takes: no division when the distance is at most half the full-force
// distance, one x/y pair if linear, a second pair and one more if quadratic.
// a two word input queue takes words while the back end works, until it is full; the
// result register holds one word under out_stall. rst clears control state
// and loads the register reset values.
module dipole_force_energy_gradient_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [dfeg_pkg::IDX_W-1:0]   wr_index,
  input  logic [dfeg_pkg::CFG_W-1:0]   wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           first_rest_x,
  input  logic signed [31:0]           first_rest_y,
  input  logic signed [31:0]           first_disp_x,
  input  logic signed [31:0]           first_disp_y,
  input  logic signed [31:0]           second_rest_x,
  input  logic signed [31:0]           second_rest_y,
  input  logic signed [31:0]           second_disp_x,
  input  logic signed [31:0]           second_disp_y,
  input  logic                         last_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [46:0]                  energy_sum,
  output logic signed [47:0]           grad_x_sum,
  output logic signed [47:0]           grad_y_sum,
  output logic                         last_out
);

  dfeg_pkg::cfg_t    cfg;
  dfeg_pkg::q_stat_t q_stat;
  dfeg_pkg::item_t   q_item;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_full  <= dfeg_pkg::CFG_W'(13);
      cfg.force_mag <= dfeg_pkg::CFG_W'(65536);
    end else if (wr_en) begin
      unique case (wr_index)
        dfeg_pkg::REG_MIN_FULL: cfg.min_full  <= wr_data;
        dfeg_pkg::REG_FORCE:    cfg.force_mag <= wr_data;
        default: ;
      endcase
    end
  end

  dfeg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_rest_x  (first_rest_x),
    .first_rest_y  (first_rest_y),
    .first_disp_x  (first_disp_x),
    .first_disp_y  (first_disp_y),
    .second_rest_x (second_rest_x),
    .second_rest_y (second_rest_y),
    .second_disp_x (second_disp_x),
    .second_disp_y (second_disp_y),
    .last_in       (last_in),
    .q_pop         (q_pop),
    .q_stat        (q_stat),
    .q_item        (q_item)
  );

  dfeg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .energy_sum (energy_sum),
    .grad_x_sum (grad_x_sum),
    .grad_y_sum (grad_y_sum),
    .last_out   (last_out)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_pop_has_word: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.valid)
    else $error("back end took a word from an empty queue");
  a_pop_spacing: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !q_pop)
    else $error("back end took two words in a row");

endmodule

FILE: dv/dipole_force_energy_gradient_top_tb.sv
// testbench for dipole_force_energy_gradient_top: random and directed dipoles, with a
// scoreboard that predicts energy and gradient sums. depends on dfeg_pkg and the top.
module dipole_force_energy_gradient_top_tb;

  localparam logic [dfeg_pkg::IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [dfeg_pkg::IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ACC_HI = (longint'(1) << (dfeg_pkg::ACC_BITS - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct {
    logic signed [31:0] frx, fry, fdx, fdy, srx, sry, sdx, sdy;
    logic last;
  } dipole_t;

  typedef struct {
    logic [46:0] energy;
    logic [47:0] gx, gy;
    logic last;
  } sums_t;

  class sum_board;
    longint min_full, force_mag;
    longint e_acc, gx_acc, gy_acc;
    sums_t pending[$];
    int errors;

    function void reset_state();
      min_full = 13; force_mag = 65536;
      e_acc = 0; gx_acc = 0; gy_acc = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [dfeg_pkg::IDX_W-1:0] idx,
                            logic [dfeg_pkg::CFG_W-1:0] val);
      if (idx == dfeg_pkg::REG_MIN_FULL) min_full = val;
      else if (idx == dfeg_pkg::REG_FORCE) force_mag = val;
    endfunction

    function longint sat_add(longint acc, longint v);
      if (v > 0 && acc > ACC_HI - v) return ACC_HI;
      if (v < 0 && acc < ACC_LO - v) return ACC_LO;
      return acc + v;
    endfunction

    function logic [47:0] scaled(longint acc);
      logic [127:0] prod, q, lim;
      logic neg;
      neg = acc < 0;
      prod = (neg ? 128'(-acc) : 128'(acc)) * 128'(force_mag);
      q = prod >> dfeg_pkg::FRAC_BITS;
      lim = 128'(ACC_HI) + (neg ? 128'd1 : 128'd0);
      if (q > lim) q = lim;
      return neg ? 48'(-q) : 48'(q);
    endfunction

    function void note_dipole(dipole_t a);
      longint dx, dy, d, m, e, gx, gy, u;
      logic signed [127:0] wx, wy, rad, t;
      sums_t s;
      dx = (longint'(a.frx) + longint'(a.fdx)) - (longint'(a.srx) + longint'(a.sdx));
      dy = (longint'(a.fry) + longint'(a.fdy)) - (longint'(a.sry) + longint'(a.sdy));
      wx = dx; wy = dy;
      rad = wx * wx + wy * wy;
      d = 0;
      for (int b = 35; b >= 0; b--) begin
        t = d | (longint'(1) << b);
        if (t * t <= rad) d = 64'(t);
      end
      m = min_full;
      e = 0; gx = 0; gy = 0;
      if (d > m) begin
        e = (4 * d - 3 * m) / 4;
        gx = dx * 65536 / d;
        gy = dy * 65536 / d;
      end else if (2 * d > m) begin
        u = 2 * d - m;
        e = (u * u) / (4 * m);
        gx = (dx * 65536 / d) * u / m;
        gy = (dy * 65536 / d) * u / m;
      end
      e_acc = sat_add(e_acc, e);
      gx_acc = sat_add(gx_acc, gx);
      gy_acc = sat_add(gy_acc, gy);
      s.energy = 47'(scaled(e_acc));
      s.gx = scaled(gx_acc);
      s.gy = scaled(gy_acc);
      s.last = a.last;
      pending.insert(pending.size(), s);
      if (a.last) begin
        e_acc = 0; gx_acc = 0; gy_acc = 0;
      end
    endfunction

    function void check_sums(sums_t got);
      sums_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, energy %h", $time, got.energy);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.energy !== w.energy) begin
        $display("%0t: energy_sum expected %h actual %h", $time, w.energy, got.energy);
        errors++;
      end
      if (got.gx !== w.gx) begin
        $display("%0t: grad_x_sum expected %h actual %h", $time, w.gx, got.gx);
        errors++;
      end
      if (got.gy !== w.gy) begin
        $display("%0t: grad_y_sum expected %h actual %h", $time, w.gy, got.gy);
        errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t: last_out expected %b actual %b", $time, w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic wr_en;
  logic [dfeg_pkg::IDX_W-1:0] wr_index;
  logic [dfeg_pkg::CFG_W-1:0] wr_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] first_rest_x, first_rest_y, first_disp_x, first_disp_y;
  logic signed [31:0] second_rest_x, second_rest_y, second_disp_x, second_disp_y;
  logic last_in, last_out;
  logic [46:0] energy_sum;
  logic signed [47:0] grad_x_sum, grad_y_sum;

  sum_board board;
  bit quiet;
  longint cycles = 0;

  dipole_force_energy_gradient_top DUT (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver stall bursts
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    sums_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[dipole_force_energy_gradient_top] ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got.energy = energy_sum; got.gx = grad_x_sum; got.gy = grad_y_sum;
      got.last = last_out;
      board.check_sums(got);
    end
  end

  task automatic send_dipole(dipole_t a);
    first_rest_x <= a.frx; first_rest_y <= a.fry;
    first_disp_x <= a.fdx; first_disp_y <= a.fdy;
    second_rest_x <= a.srx; second_rest_y <= a.sry;
    second_disp_x <= a.sdx; second_disp_y <= a.sdy;
    last_in <= a.last;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_dipole(a);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [dfeg_pkg::IDX_W-1:0] idx,
                           logic [dfeg_pkg::CFG_W-1:0] val);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    board.write_reg(idx, val);
  endtask

  // dipole with a given separation, endpoints spread over rest and displacement
  function automatic dipole_t make_sep(longint dx, longint dy, logic last);
    dipole_t a;
    int s;
    s = $signed($urandom_range(0, 2000)) - 1000;
    a.frx = 32'(dx >>> 1) + s; a.fdx = 32'(dx - (dx >>> 1));
    a.fry = 32'(dy >>> 1); a.fdy = 32'(dy - (dy >>> 1));
    a.srx = s; a.sdx = 0; a.sry = 0; a.sdy = 0;
    a.last = last;
    return a;
  endfunction

  function automatic dipole_t rand_dipole();
    dipole_t a;
    longint t, m;
    logic last;
    last = ($urandom_range(0, 7) == 0);
    m = board.min_full;
    case ($urandom_range(0, 9))
      0, 1: begin
        a.frx = $urandom; a.fry = $urandom; a.fdx = $urandom; a.fdy = $urandom;
        a.srx = $urandom; a.sry = $urandom; a.sdx = $urandom; a.sdy = $urandom;
        a.last = last;
      end
      2: begin
        a = make_sep(0, 0, last);
        a.fdx = $urandom; a.sdx = a.fdx; a.fry = $urandom; a.sry = a.fry;
      end
      default: begin
        // around the full-force distance, where the quadratic piece lives
        t = m / 2 + $urandom_range(0, 32'(m - m / 4 + 8));
        if (t > 64'd2000000000) t = 2000000000;
        a = make_sep($urandom_range(0, 1) ? t : -t,
                     $signed($urandom_range(0, 32'(t / 8 + 1))) * ($urandom_range(0, 1) ? 1 : -1),
                     last);
      end
    endcase
    return a;
  endfunction

  initial begin
    longint mins[5];
    longint forces[5];
    dipole_t a;
    board = new();
    board.reset_state();
    quiet = 0;
    rst = 1; wr_en = 0; wr_index = dfeg_pkg::REG_MIN_FULL; wr_data = 0;
    in_valid = 0; last_in = 0;
    first_rest_x = 0; first_rest_y = 0; first_disp_x = 0; first_disp_y = 0;
    second_rest_x = 0; second_rest_y = 0; second_disp_x = 0; second_disp_y = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // directed part at the reset settings
    send_dipole(make_sep(0, 0, 0));
    send_dipole(make_sep(13, 0, 0));
    send_dipole(make_sep(14, 0, 0));
    send_dipole(make_sep(7, 0, 0));
    send_dipole(make_sep(6, 0, 0));
    send_dipole(make_sep(0, -10, 0));
    send_dipole(make_sep(-9, 0, 1));
    a.frx = 32'h7fffffff; a.fry = 32'h7fffffff; a.fdx = 32'h7fffffff; a.fdy = 32'h7fffffff;
    a.srx = 32'h80000000; a.sry = 32'h80000000; a.sdx = 32'h80000000; a.sdy = 32'h80000000;
    a.last = 0;
    repeat (4) send_dipole(a);
    a.frx = 32'h80000000; a.fry = 32'h7fffffff; a.fdx = 32'h80000000; a.fdy = 32'h7fffffff;
    a.srx = 32'h7fffffff; a.sry = 32'h80000000; a.sdx = 32'h7fffffff; a.sdy = 32'h80000000;
    a.last = 1;
    send_dipole(a);
    drain();

    mins[0] = 0;           forces[0] = 65536;
    mins[1] = 32'h7fffffff; forces[1] = 32'h7fffffff;
    mins[2] = 262144;      forces[2] = 0;
    mins[3] = $urandom_range(1, 1 << 24); forces[3] = $urandom_range(0, 32'h7fffffff);
    mins[4] = $urandom_range(1, 1 << 20); forces[4] = $urandom_range(1, 1 << 18);
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_SPARE_A, dfeg_pkg::CFG_W'($urandom));
      write_reg(dfeg_pkg::REG_MIN_FULL, dfeg_pkg::CFG_W'(mins[p]));
      write_reg(dfeg_pkg::REG_FORCE, dfeg_pkg::CFG_W'(forces[p]));
      write_reg(REG_SPARE_B, dfeg_pkg::CFG_W'($urandom));
      for (int i = 0; i < 190; i++) begin
        if (p == 4 && i > 100) quiet = 1;
        send_dipole(rand_dipole());
      end
      a = make_sep(0, 0, 1);
      send_dipole(a);
      if (p != 4) drain();
    end

    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("[dipole_force_energy_gradient_top] OK");
    end else begin
      $display("[dipole_force_energy_gradient_top] ERROR");
    end
    $finish;
  end
endmodule
